FILE: sv/fsr_pkg.sv
`default_nettype none
package fsr_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_MOVE = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

endpackage
`default_nettype wire

FILE: sv/fsr_store.sv
`default_nettype none
module fsr_store (
  input  wire logic               clk,
  input  wire fsr_pkg::store_req_t req,
  output logic [7:0]              rdata
);

  logic [7:0] mem [fsr_pkg::FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/sync_checksum_frame_receiver_top.sv
`default_nettype none
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------
// input    | in_valid / in_ready        | rx_byte
// output   | out_valid / out_ready      | frame_byte, byte_index, frame_last
// config   | wr_en (no wait)            | wr_data -> sync_value
//
// The completing byte starts a checksum pass through the single read port of the
// frame store; a good frame then drains at one beat per cycle while out_ready is
// high, a bad one is rescanned for the sync value and, if one is found, moved
// down. in_ready is low meanwhile.
// rst is synchronous; the store itself is not cleared. Output stalls hold the drain.
module sync_checksum_frame_receiver_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      frame_byte,
  output logic [5:0]      byte_index,
  output logic            frame_last,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_data
);

  localparam int N     = fsr_pkg::FRAME_BYTES;
  localparam int IDX_W = fsr_pkg::IDX_W;
  localparam int CNT_W = fsr_pkg::CNT_W;

  fsr_pkg::state_t     state, state_next;
  fsr_pkg::store_req_t req;
  logic [CNT_W-1:0]    ptr, ptr_next;
  logic [CNT_W-1:0]    fill_count, fill_count_next;
  logic [IDX_W-1:0]    pidx;
  logic [IDX_W-1:0]    off, off_next;
  logic [7:0]          acc, acc_next;
  logic [7:0]          b1, b1_next;
  logic [7:0]          sync_value;
  logic [7:0]          rd_data;
  logic [7:0]          acc_sum;
  logic                pend, pend_next;
  logic                issue, load, consume, ptr_end;

  fsr_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rd_data)
  );

  assign in_ready = (state == fsr_pkg::ST_IDLE);
  assign ptr_end  = (ptr == CNT_W'(N));
  assign acc_sum  = acc + rd_data;
  assign load     = (state == fsr_pkg::ST_EMIT) && pend && (!out_valid || out_ready);
  assign consume  = (state != fsr_pkg::ST_EMIT) || load;
  assign pend_next = issue || (pend && !consume);

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    fill_count_next = fill_count;
    off_next        = off;
    acc_next        = acc;
    b1_next         = b1;
    issue           = 1'b0;
    req.we          = 1'b0;
    req.waddr       = fill_count[IDX_W-1:0];
    req.wdata       = rx_byte;
    req.re          = 1'b0;
    req.raddr       = ptr[IDX_W-1:0];
    unique case (state)
      fsr_pkg::ST_IDLE: begin
        if (in_valid && !(fill_count == '0 && rx_byte != sync_value)) begin
          req.we = 1'b1;
          if (fill_count == CNT_W'(N - 1)) begin
            state_next      = fsr_pkg::ST_SUM;
            ptr_next        = CNT_W'(1);
            acc_next        = '0;
            fill_count_next = '0;
          end else begin
            fill_count_next = fill_count + CNT_W'(1);
          end
        end
      end
      fsr_pkg::ST_SUM: begin
        issue = !ptr_end;
        if (pend) begin
          if (pidx == IDX_W'(1)) begin
            b1_next = rd_data;
          end else begin
            acc_next = acc_sum;
          end
          if (ptr_end) begin
            if (acc_sum == b1) begin
              state_next = fsr_pkg::ST_EMIT;
              ptr_next   = '0;
            end else begin
              state_next = fsr_pkg::ST_SCAN;
              ptr_next   = CNT_W'(1);
            end
          end
        end
        if (issue) begin
          ptr_next = ptr + CNT_W'(1);
        end
      end
      fsr_pkg::ST_SCAN: begin
        if (pend && rd_data == sync_value) begin
          state_next = fsr_pkg::ST_MOVE;
          ptr_next   = CNT_W'(pidx);
          off_next   = pidx;
        end else begin
          issue = !ptr_end;
          if (issue) begin
            ptr_next = ptr + CNT_W'(1);
          end
          if (pend && pidx == IDX_W'(N - 1)) begin
            state_next      = fsr_pkg::ST_IDLE;
            fill_count_next = '0;
          end
        end
      end
      fsr_pkg::ST_MOVE: begin
        issue = !ptr_end;
        if (issue) begin
          ptr_next = ptr + CNT_W'(1);
        end
        if (pend) begin
          req.we    = 1'b1;
          req.waddr = pidx - off;
          req.wdata = rd_data;
          if (ptr_end) begin
            state_next      = fsr_pkg::ST_IDLE;
            fill_count_next = CNT_W'(N) - CNT_W'(off);
          end
        end
      end
      fsr_pkg::ST_EMIT: begin
        issue = !ptr_end && (!pend || load);
        if (issue) begin
          ptr_next = ptr + CNT_W'(1);
        end
        if (load && ptr_end) begin
          state_next      = fsr_pkg::ST_IDLE;
          fill_count_next = '0;
        end
      end
      default: begin
        state_next = fsr_pkg::ST_IDLE;
      end
    endcase
    req.re = issue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fsr_pkg::ST_IDLE;
      fill_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
      sync_value <= 8'hFF;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      pend       <= pend_next;
      if (wr_en) begin
        sync_value <= wr_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    off <= off_next;
    acc <= acc_next;
    b1  <= b1_next;
    if (issue) begin
      pidx <= ptr[IDX_W-1:0];
    end
    if (load) begin
      frame_byte <= rd_data;
      byte_index <= 6'(pidx);
      frame_last <= (pidx == IDX_W'(N - 1));
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == fsr_pkg::ST_IDLE |-> !pend)
    else $error("read pending while idle");

  a_fill_below_frame: assert property (@(posedge clk) disable iff (rst)
    fill_count < CNT_W'(N))
    else $error("fill count reached frame length");

  a_move_offset: assert property (@(posedge clk) disable iff (rst)
    state == fsr_pkg::ST_MOVE |-> off != '0)
    else $error("move with zero offset");

  a_ready_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && fill_count == CNT_W'(N - 1) |=> !in_ready)
    else $error("ready during frame check");

endmodule
`default_nettype wire

FILE: verif/sync_checksum_frame_receiver_chk.sv
`timescale 1ns / 100ps
module sync_checksum_frame_receiver_chk (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] frame_byte,
  input  logic [5:0] byte_index,
  input  logic       frame_last,
  input  logic       wr_en,
  input  logic [7:0] wr_data,
  output int         fail_count,
  output int         beats_due
);

  typedef struct packed {
    logic [7:0] byte_val;
    logic [5:0] pos;
    logic       is_last;
  } frame_beat_t;

  frame_beat_t beats_expected[$];
  logic [7:0]  held [fsr_pkg::FRAME_BYTES];
  int          held_count;
  logic [7:0]  sync_byte;
  int          mismatches = 0;
  int          due_n = 0;

  assign fail_count = mismatches;
  assign beats_due  = due_n;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t chk: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // frame buffer update for one received byte; good frames queue their beats
  function automatic void absorb_byte(input logic [7:0] b);
    logic [7:0]  acc;
    int          found;
    frame_beat_t beat;
    if (held_count == 0) begin
      if (b != sync_byte) return;
      held[0] = b;
      held_count = 1;
    end else if (held_count < fsr_pkg::FRAME_BYTES) begin
      held[held_count] = b;
      held_count++;
    end else begin
      held_count = 0;
      return;
    end
    if (held_count < fsr_pkg::FRAME_BYTES) return;
    acc = '0;
    for (int k = 2; k < fsr_pkg::FRAME_BYTES; k++) acc += held[k];
    if (acc != held[1]) begin
      found = 0;
      for (int k = 1; k < fsr_pkg::FRAME_BYTES && found == 0; k++)
        if (held[k] == sync_byte) found = k;
      if (found == 0) begin
        held_count = 0;
      end else begin
        for (int k = 0; k < fsr_pkg::FRAME_BYTES - found; k++) held[k] = held[k + found];
        held_count = fsr_pkg::FRAME_BYTES - found;
      end
      return;
    end
    for (int k = 0; k < fsr_pkg::FRAME_BYTES; k++) begin
      beat.byte_val = held[k];
      beat.pos      = 6'(k);
      beat.is_last  = (k == fsr_pkg::FRAME_BYTES - 1);
      beats_expected.push_back(beat);
    end
    held_count = 0;
  endfunction

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      held_count = 0;
      sync_byte  = 8'hFF;
      beats_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (beats_expected.size() == 0) begin
          report_mismatch("unexpected beat, frame_byte", frame_byte, 0);
        end else begin
          want = beats_expected.pop_front();
          if (frame_byte != want.byte_val)
            report_mismatch("frame_byte", frame_byte, want.byte_val);
          if (byte_index != want.pos)
            report_mismatch("byte_index", byte_index, want.pos);
          if (frame_last != want.is_last)
            report_mismatch("frame_last", frame_last, want.is_last);
        end
      end
      if (in_valid && in_ready) absorb_byte(rx_byte);
      if (wr_en) sync_byte = wr_data;
    end
    due_n <= beats_expected.size();
  end

endmodule

FILE: verif/tb_sync_checksum_frame_receiver_top.sv
`timescale 1ns / 100ps
module tb_sync_checksum_frame_receiver_top;

  localparam int          FRAME_ITEMS  = 380;
  localparam int          SETTLE       = 4 * fsr_pkg::FRAME_BYTES;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic       frame_last;
  logic       wr_en;
  logic [7:0] wr_data;
  int         fail_count;
  int         beats_due;

  logic [7:0] sync_now;
  logic       in_calm;
  int         frame_items;
  logic [7:0] pkt [fsr_pkg::FRAME_BYTES];
  logic [7:0] nxt [fsr_pkg::FRAME_BYTES];

  always #5 clk = ~clk;

  sync_checksum_frame_receiver_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .frame_last (frame_last),
    .wr_en      (wr_en),
    .wr_data    (wr_data)
  );

  sync_checksum_frame_receiver_chk i_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .frame_last (frame_last),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  function automatic logic [7:0] non_sync_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == sync_now);
    return b;
  endfunction

  function automatic logic [7:0] pkt_sum();
    logic [7:0] acc;
    acc = '0;
    for (int k = 2; k < fsr_pkg::FRAME_BYTES; k++) acc += pkt[k];
    return acc;
  endfunction

  task automatic build_good_frame();
    logic [7:0] acc;
    acc = '0;
    nxt[0] = sync_now;
    for (int k = 2; k < fsr_pkg::FRAME_BYTES; k++) begin
      nxt[k] = 8'($urandom);
      acc += nxt[k];
    end
    nxt[1] = acc;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit frame_part);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (frame_part) frame_items++;
  endtask

  task automatic drain_frames(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_sync(input logic [7:0] v);
    drain_frames(SETTLE);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en    <= 1'b0;
    sync_now = v;
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_byte(non_sync_byte(), 1'b0);
  endtask

  task automatic send_good_frame();
    build_good_frame();
    for (int k = 0; k < fsr_pkg::FRAME_BYTES; k++) send_byte(nxt[k], 1'b1);
  endtask

  // bad checksum, no sync after position 0: buffer empties
  task automatic send_bad_frame();
    pkt[0] = sync_now;
    do begin
      for (int k = 1; k < fsr_pkg::FRAME_BYTES; k++) pkt[k] = non_sync_byte();
    end while (pkt_sum() == pkt[1]);
    for (int k = 0; k < fsr_pkg::FRAME_BYTES; k++) send_byte(pkt[k], 1'b1);
  endtask

  // bad checksum with the next frame starting at position at; then complete it
  task automatic send_resync(input int at);
    do begin
      build_good_frame();
      pkt[0] = sync_now;
      for (int k = 1; k < at; k++) pkt[k] = non_sync_byte();
      for (int k = at; k < fsr_pkg::FRAME_BYTES; k++) pkt[k] = nxt[k - at];
    end while (pkt_sum() == pkt[1]);
    for (int k = 0; k < fsr_pkg::FRAME_BYTES; k++) send_byte(pkt[k], 1'b1);
    for (int k = fsr_pkg::FRAME_BYTES - at; k < fsr_pkg::FRAME_BYTES; k++)
      send_byte(nxt[k], 1'b1);
  endtask

  initial begin
    int stall;
    bit out_calm;
    out_ready = 1'b0;
    out_calm  = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int         seq_n;
    int         pick;
    logic [7:0] plan [4];
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = '0;
    wr_en       = 1'b0;
    wr_data     = '0;
    sync_now    = 8'hFF;
    in_calm     = 1'b0;
    frame_items = 0;
    plan[0] = 8'hFF;
    plan[1] = 8'($urandom);
    plan[2] = 8'h00;
    plan[3] = 8'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // hunting: everything but the sync byte is dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    // sync value moved mid-frame; held bytes stay
    build_good_frame();
    for (int k = 0; k < 10; k++) send_byte(nxt[k], 1'b1);
    set_sync(8'h00);
    for (int k = 10; k < fsr_pkg::FRAME_BYTES; k++) send_byte(nxt[k], 1'b1);

    seq_n = 0;
    while (frame_items < FRAME_ITEMS - fsr_pkg::FRAME_BYTES) begin
      if (seq_n > 1) set_sync(plan[(seq_n - 2) % 4]);
      in_calm = ($urandom_range(0, 3) == 0);
      send_noise();
      if (seq_n == 0) begin
        send_resync(1);
      end else if (seq_n == 1) begin
        send_resync(fsr_pkg::FRAME_BYTES - 1);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) send_good_frame();
        else if (pick < 8) send_resync($urandom_range(1, fsr_pkg::FRAME_BYTES - 1));
        else send_bad_frame();
      end
      seq_n++;
    end

    drain_frames(SETTLE);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
sv/fsr_pkg.sv
sv/fsr_store.sv
sv/sync_checksum_frame_receiver_top.sv
verif/sync_checksum_frame_receiver_chk.sv
verif/tb_sync_checksum_frame_receiver_top.sv
